[src/bmb_pkg.sv]
// Billboard matrix builder: shared widths, types, register codes and helpers.
// No dependencies; every other file uses it by scoped names.
package bmb_pkg;

    localparam int VEC_W  = 16;              // Q2.14 vector component
    localparam int POS_W  = 32;              // Q16.16 position
    localparam int DIM_W  = 31;              // Q15.16 unsigned size
    localparam int F_W    = 17;              // negated facing component
    localparam int PRD_W  = 33;              // facing x axis product
    localparam int DOT_W  = 35;              // dot product
    localparam int V_W    = 49;              // projected vector, Q.42 (Q.14 outside axis mode)
    localparam int M_W    = 48;              // magnitude of projected vector
    localparam int K_W    = 5;               // normalizing shift
    localparam int BL_W   = 6;               // bit length of a magnitude
    localparam int MAG_W  = 24;              // magnitude after shift
    localparam int SQ_W   = 48;
    localparam int SUM_W  = 50;              // sum of squares
    localparam int ROOT_W = 25;              // square root
    localparam int NUM_W  = 39;              // divider numerator
    localparam int Q_W    = 15;              // quotient
    localparam int CR_W   = 33;              // cross product difference
    localparam int PW_W   = 48;              // size x component
    localparam int T_W    = 49;              // translation before rounding
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 32;
    localparam int IN_W   = 192;
    localparam int OUT_W  = 240;

    typedef enum logic [IDX_W-1:0] {
        REG_AXIS_MODE   = 3'd0,
        REG_AXIS_X      = 3'd1,
        REG_AXIS_Y      = 3'd2,
        REG_AXIS_Z      = 3'd3,
        REG_QUAD_WIDTH  = 3'd4,
        REG_QUAD_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                         axis_mode;
        logic [2:0][VEC_W-1:0]        axis;
        logic [DIM_W-1:0]             quad_width;
        logic [DIM_W-1:0]             quad_height;
    } cfg_t;

    // Payload that rides alongside the length and division units
    typedef struct packed {
        logic [2:0][VEC_W-1:0]        r2;
        logic [2:0][POS_W-1:0]        pos;
        logic [2:0]                   neg;
        logic [2:0][MAG_W-1:0]        mag;
    } side_t;

    function automatic logic signed [VEC_W-1:0] sat16(input logic signed [CR_W-1:0] v);
        logic signed [VEC_W-1:0] r;
        if (v > CR_W'(32767))
            r = 16'sh7fff;
        else if (v < -CR_W'(32768))
            r = 16'sh8000;
        else
            r = v[VEC_W-1:0];
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [T_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > T_W'(64'sd2147483647))
            r = 32'sh7fffffff;
        else if (v < -T_W'(64'sd2147483648))
            r = 32'sh80000000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

[src/bmb_front.sv]
// Front end: negation, axis projection, magnitudes, normalizing shift, sum of squares.
// Uses bmb_pkg. Eight register stages, all advancing on ce.
module bmb_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   ce,
    input  logic                                   in_valid,
    input  logic [2:0][bmb_pkg::VEC_W-1:0]         face,
    input  logic [2:0][bmb_pkg::VEC_W-1:0]         up,
    input  logic [2:0][bmb_pkg::POS_W-1:0]         pos,
    input  bmb_pkg::cfg_t                          cfg,
    output logic                                   out_valid,
    output logic [bmb_pkg::SUM_W-1:0]              sum,
    output bmb_pkg::side_t                         side
);

    logic [7:0] valid_reg;

    logic signed [bmb_pkg::F_W-1:0]    f_next   [3];
    logic signed [bmb_pkg::PRD_W-1:0]  prod_next[3];
    logic signed [bmb_pkg::F_W-1:0]    f1_reg   [3];
    logic signed [bmb_pkg::PRD_W-1:0]  prod1_reg[3];
    logic [2:0][bmb_pkg::VEC_W-1:0]    r2_1_reg, r2_2_reg, r2_3_reg, r2_4_reg, r2_5_reg;
    logic [2:0][bmb_pkg::POS_W-1:0]    pos1_reg, pos2_reg, pos3_reg, pos4_reg, pos5_reg;

    logic signed [bmb_pkg::DOT_W-1:0]  dot_next, dot2_reg;
    logic signed [bmb_pkg::F_W-1:0]    f2_reg   [3];

    logic signed [bmb_pkg::V_W-1:0]    v_next   [3];
    logic signed [bmb_pkg::V_W-1:0]    v3_reg   [3];

    logic [bmb_pkg::M_W-1:0]           m_next   [3];
    logic [bmb_pkg::M_W-1:0]           m4_reg   [3];
    logic [bmb_pkg::M_W-1:0]           m5_reg   [3];
    logic [2:0]                        neg_next, neg4_reg, neg5_reg;

    logic [bmb_pkg::M_W-1:0]           any_bits;
    logic [bmb_pkg::BL_W-1:0]          blen;
    logic [bmb_pkg::K_W-1:0]           k_next, k5_reg;

    bmb_pkg::side_t                    side_next, side6_reg, side7_reg, side8_reg;
    logic [bmb_pkg::SQ_W-1:0]          sq_next  [3];
    logic [bmb_pkg::SQ_W-1:0]          sq7_reg  [3];
    logic [bmb_pkg::SUM_W-1:0]         sum_next, sum8_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_next[i]    = -bmb_pkg::F_W'($signed(face[i]));
            prod_next[i] = bmb_pkg::PRD_W'(f_next[i]) * bmb_pkg::PRD_W'($signed(cfg.axis[i]));
        end
        dot_next = bmb_pkg::DOT_W'(prod1_reg[0]) + bmb_pkg::DOT_W'(prod1_reg[1])
                 + bmb_pkg::DOT_W'(prod1_reg[2]);
        for (int i = 0; i < 3; i++) begin
            if (cfg.axis_mode)
                v_next[i] = (bmb_pkg::V_W'(f2_reg[i]) <<< 28)
                          - bmb_pkg::V_W'(dot2_reg) * bmb_pkg::V_W'($signed(r2_2_reg[i]));
            else
                v_next[i] = bmb_pkg::V_W'(f2_reg[i]);
            neg_next[i] = v3_reg[i][bmb_pkg::V_W-1];
            m_next[i]   = neg_next[i] ? bmb_pkg::M_W'(-v3_reg[i]) : bmb_pkg::M_W'(v3_reg[i]);
        end
        // smallest shift that brings every magnitude under 2^24
        any_bits = m4_reg[0] | m4_reg[1] | m4_reg[2];
        blen = '0;
        for (int b = 0; b < bmb_pkg::M_W; b++)
            if (any_bits[b])
                blen = bmb_pkg::BL_W'(b + 1);
        k_next = (blen > bmb_pkg::BL_W'(bmb_pkg::MAG_W))
               ? bmb_pkg::K_W'(blen - bmb_pkg::BL_W'(bmb_pkg::MAG_W)) : '0;
        side_next.r2  = r2_5_reg;
        side_next.pos = pos5_reg;
        side_next.neg = neg5_reg;
        for (int i = 0; i < 3; i++)
            side_next.mag[i] = bmb_pkg::MAG_W'(m5_reg[i] >> k5_reg);
        for (int i = 0; i < 3; i++)
            sq_next[i] = bmb_pkg::SQ_W'(side6_reg.mag[i]) * bmb_pkg::SQ_W'(side6_reg.mag[i]);
        sum_next = bmb_pkg::SUM_W'(sq7_reg[0]) + bmb_pkg::SUM_W'(sq7_reg[1])
                 + bmb_pkg::SUM_W'(sq7_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f1_reg    <= f_next;
            prod1_reg <= prod_next;
            for (int i = 0; i < 3; i++)
                r2_1_reg[i] <= cfg.axis_mode ? cfg.axis[i] : up[i];
            pos1_reg  <= pos;
            dot2_reg  <= dot_next;
            f2_reg    <= f1_reg;
            r2_2_reg  <= r2_1_reg;
            pos2_reg  <= pos1_reg;
            v3_reg    <= v_next;
            r2_3_reg  <= r2_2_reg;
            pos3_reg  <= pos2_reg;
            m4_reg    <= m_next;
            neg4_reg  <= neg_next;
            r2_4_reg  <= r2_3_reg;
            pos4_reg  <= pos3_reg;
            m5_reg    <= m4_reg;
            neg5_reg  <= neg4_reg;
            k5_reg    <= k_next;
            r2_5_reg  <= r2_4_reg;
            pos5_reg  <= pos4_reg;
            side6_reg <= side_next;
            sq7_reg   <= sq_next;
            side7_reg <= side6_reg;
            sum8_reg  <= sum_next;
            side8_reg <= side7_reg;
        end
    end

    assign out_valid = valid_reg[7];
    assign sum       = sum8_reg;
    assign side      = side8_reg;

endmodule

[src/bmb_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Uses bmb_pkg. Carries the side payload in step with the root.
module bmb_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [bmb_pkg::SUM_W-1:0]     sum,
    input  bmb_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [bmb_pkg::ROOT_W-1:0]    root,
    output bmb_pkg::side_t                side_out
);

    localparam int N = bmb_pkg::ROOT_W;

    logic [bmb_pkg::SUM_W-1:0]  rem_reg  [N];
    logic [bmb_pkg::ROOT_W-1:0] root_reg [N];
    bmb_pkg::side_t             side_reg [N];
    logic [N-1:0]               valid_reg;

    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam int B = N - 1 - s;
        logic [bmb_pkg::SUM_W-1:0]  cur_rem;
        logic [bmb_pkg::ROOT_W-1:0] cur_root;
        bmb_pkg::side_t             cur_side;
        logic                       cur_valid;
        logic [bmb_pkg::SUM_W-1:0]  trial;
        logic                       take;

        if (s == 0) begin : g_first
            assign cur_rem   = sum;
            assign cur_root  = '0;
            assign cur_side  = side_in;
            assign cur_valid = in_valid;
        end else begin : g_next
            assign cur_rem   = rem_reg[s-1];
            assign cur_root  = root_reg[s-1];
            assign cur_side  = side_reg[s-1];
            assign cur_valid = valid_reg[s-1];
        end

        // (r + 2^b)^2 - r^2
        assign trial = (bmb_pkg::SUM_W'(cur_root) << (B + 1))
                     | (bmb_pkg::SUM_W'(1) << (2 * B));
        assign take  = cur_rem >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (ce) begin
                valid_reg[s] <= cur_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[s]  <= take ? cur_rem - trial : cur_rem;
                root_reg[s] <= take ? (cur_root | (bmb_pkg::ROOT_W'(1) << B)) : cur_root;
                side_reg[s] <= cur_side;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = root_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

[src/bmb_div.sv]
// Pipelined restoring divider, three lanes: round(mag * 2^14 / root).
// Uses bmb_pkg. One quotient bit per stage; zero root gives zero.
module bmb_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ce,
    input  logic                                in_valid,
    input  logic [bmb_pkg::ROOT_W-1:0]          root,
    input  bmb_pkg::side_t                      side_in,
    output logic                                out_valid,
    output logic [2:0][bmb_pkg::Q_W-1:0]        quot,
    output bmb_pkg::side_t                      side_out
);

    localparam int N = bmb_pkg::Q_W;

    logic [2:0][bmb_pkg::NUM_W-1:0] rem_reg  [N];
    logic [2:0][bmb_pkg::Q_W-1:0]   q_reg    [N];
    logic [bmb_pkg::ROOT_W-1:0]     den_reg  [N];
    bmb_pkg::side_t                 side_reg [N];
    logic [N-1:0]                   zero_reg;
    logic [N-1:0]                   valid_reg;

    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam int B = N - 1 - s;
        logic [2:0][bmb_pkg::NUM_W-1:0] cur_rem;
        logic [2:0][bmb_pkg::Q_W-1:0]   cur_q;
        logic [bmb_pkg::ROOT_W-1:0]     cur_den;
        bmb_pkg::side_t                 cur_side;
        logic                           cur_zero;
        logic                           cur_valid;
        logic [bmb_pkg::NUM_W-1:0]      sub;
        logic [2:0][bmb_pkg::NUM_W-1:0] rem_next;
        logic [2:0][bmb_pkg::Q_W-1:0]   q_next;

        if (s == 0) begin : g_first
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign cur_rem[i] = (bmb_pkg::NUM_W'(side_in.mag[i]) << 14)
                                  + bmb_pkg::NUM_W'(root >> 1);
            end
            assign cur_q     = '0;
            assign cur_den   = root;
            assign cur_side  = side_in;
            assign cur_zero  = (root == '0);
            assign cur_valid = in_valid;
        end else begin : g_next
            assign cur_rem   = rem_reg[s-1];
            assign cur_q     = q_reg[s-1];
            assign cur_den   = den_reg[s-1];
            assign cur_side  = side_reg[s-1];
            assign cur_zero  = zero_reg[s-1];
            assign cur_valid = valid_reg[s-1];
        end

        assign sub = bmb_pkg::NUM_W'(cur_den) << B;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                if (cur_rem[i] >= sub) begin
                    rem_next[i] = cur_rem[i] - sub;
                    q_next[i]   = cur_q[i] | (bmb_pkg::Q_W'(1) << B);
                end else begin
                    rem_next[i] = cur_rem[i];
                    q_next[i]   = cur_q[i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (ce) begin
                valid_reg[s] <= cur_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
                den_reg[s]  <= cur_den;
                side_reg[s] <= cur_side;
                zero_reg[s] <= cur_zero;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quot      = zero_reg[N-1] ? '0 : q_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

[src/bmb_back.sv]
// Back end: signed row 0, cross product row 1, translation.
// Uses bmb_pkg. Five register stages, all advancing on ce.
module bmb_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ce,
    input  logic                                in_valid,
    input  logic [2:0][bmb_pkg::Q_W-1:0]        quot,
    input  bmb_pkg::side_t                      side,
    input  bmb_pkg::cfg_t                       cfg,
    output logic                                out_valid,
    output logic [2:0][bmb_pkg::VEC_W-1:0]      r0,
    output logic [2:0][bmb_pkg::VEC_W-1:0]      r1,
    output logic [2:0][bmb_pkg::VEC_W-1:0]      r2,
    output logic [2:0][bmb_pkg::POS_W-1:0]      tr
);

    logic [4:0] valid_reg;

    logic [2:0][bmb_pkg::VEC_W-1:0] r0_next, r0_1_reg, r0_2_reg, r0_3_reg, r0_4_reg, r0_5_reg;
    logic [2:0][bmb_pkg::VEC_W-1:0] r2_1_reg, r2_2_reg, r2_3_reg, r2_4_reg, r2_5_reg;
    logic [2:0][bmb_pkg::POS_W-1:0] pos1_reg, pos2_reg, pos3_reg, pos4_reg;

    logic signed [bmb_pkg::CR_W-1:0] cd_next [3];
    logic signed [bmb_pkg::CR_W-1:0] cd2_reg [3];
    logic signed [bmb_pkg::CR_W-1:0] rnd     [3];
    logic [2:0][bmb_pkg::VEC_W-1:0]  r1_next, r1_3_reg, r1_4_reg, r1_5_reg;

    logic signed [bmb_pkg::PW_W-1:0] pw_next [3];
    logic signed [bmb_pkg::PW_W-1:0] ph_next [3];
    logic signed [bmb_pkg::PW_W-1:0] pw4_reg [3];
    logic signed [bmb_pkg::PW_W-1:0] ph4_reg [3];
    logic signed [bmb_pkg::T_W-1:0]  t_sum   [3];
    logic signed [bmb_pkg::T_W-1:0]  t_rnd   [3];
    logic [2:0][bmb_pkg::POS_W-1:0]  tr_next, tr5_reg;

    function automatic logic signed [bmb_pkg::CR_W-1:0] mul(
        input logic [bmb_pkg::VEC_W-1:0] a,
        input logic [bmb_pkg::VEC_W-1:0] b
    );
        return bmb_pkg::CR_W'($signed(a)) * bmb_pkg::CR_W'($signed(b));
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++)
            r0_next[i] = side.neg[i] ? -bmb_pkg::VEC_W'(quot[i]) : bmb_pkg::VEC_W'(quot[i]);

        cd_next[0] = mul(r0_1_reg[2], r2_1_reg[1]) - mul(r2_1_reg[2], r0_1_reg[1]);
        cd_next[1] = mul(r2_1_reg[2], r0_1_reg[0]) - mul(r0_1_reg[2], r2_1_reg[0]);
        cd_next[2] = mul(r0_1_reg[1], r2_1_reg[0]) - mul(r2_1_reg[1], r0_1_reg[0]);

        for (int i = 0; i < 3; i++) begin
            // round half up by 14 bits
            rnd[i]     = (cd2_reg[i] + bmb_pkg::CR_W'(8192)) >>> 14;
            r1_next[i] = bmb_pkg::sat16(rnd[i]);
            pw_next[i] = bmb_pkg::PW_W'($signed({1'b0, cfg.quad_width}))
                       * bmb_pkg::PW_W'($signed(r1_3_reg[i]));
            ph_next[i] = bmb_pkg::PW_W'($signed({1'b0, cfg.quad_height}))
                       * bmb_pkg::PW_W'($signed(r2_3_reg[i]));
            t_sum[i]   = (bmb_pkg::T_W'($signed(pos4_reg[i])) <<< 15)
                       - bmb_pkg::T_W'(pw4_reg[i]) - bmb_pkg::T_W'(ph4_reg[i]);
            t_rnd[i]   = (t_sum[i] + bmb_pkg::T_W'(16384)) >>> 15;
            tr_next[i] = bmb_pkg::sat32(t_rnd[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            r0_1_reg <= r0_next;
            r2_1_reg <= side.r2;
            pos1_reg <= side.pos;
            cd2_reg  <= cd_next;
            r0_2_reg <= r0_1_reg;
            r2_2_reg <= r2_1_reg;
            pos2_reg <= pos1_reg;
            r1_3_reg <= r1_next;
            r0_3_reg <= r0_2_reg;
            r2_3_reg <= r2_2_reg;
            pos3_reg <= pos2_reg;
            pw4_reg  <= pw_next;
            ph4_reg  <= ph_next;
            r1_4_reg <= r1_3_reg;
            r0_4_reg <= r0_3_reg;
            r2_4_reg <= r2_3_reg;
            pos4_reg <= pos3_reg;
            tr5_reg  <= tr_next;
            r1_5_reg <= r1_4_reg;
            r0_5_reg <= r0_4_reg;
            r2_5_reg <= r2_4_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign r0        = r0_5_reg;
    assign r1        = r1_5_reg;
    assign r2        = r2_5_reg;
    assign tr        = tr5_reg;

endmodule

[src/billboard_matrix_builder.sv]
// Billboard matrix builder top level: configuration registers, pipeline, output buffer.
// Uses bmb_pkg, bmb_front, bmb_isqrt, bmb_div and bmb_back.
//
//  channel   direction  handshake                 word
//  s_        in         s_tvalid / s_tready       face, up, position (192 bits)
//  m_        out        m_tvalid / m_tready       rows 0..2, translation (240 bits)
//  cfg_      in         cfg_valid / cfg_ready     register index, data
//
// One word accepted per cycle while the output buffer has a free slot.
// Words pass through the front end, square root, divider and back end into
// the output buffer. Reset (aresetn low, synchronous) clears all valid bits,
// the output buffer and the registers to their defaults. All stages advance
// together and freeze only when the two-word output buffer is full, so a
// stall holds every word in place; s_tready is a register decode.
module billboard_matrix_builder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // face_x, face_y, face_z, up_x, up_y, up_z, pos_x, pos_y, pos_z
    input  logic [bmb_pkg::IN_W-1:0]       s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // r0_x, r0_y, r0_z, r1_x, r1_y, r1_z, r2_x, r2_y, r2_z, tr_x, tr_y, tr_z
    output logic [bmb_pkg::OUT_W-1:0]      m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bmb_pkg::IDX_W-1:0]      cfg_index,
    input  logic [bmb_pkg::CFG_W-1:0]      cfg_data
);

    bmb_pkg::cfg_t cfg_reg;

    logic                                  ce;
    logic                                  in_valid;
    logic                                  fr_valid, sq_valid, dv_valid, bk_valid;
    logic [bmb_pkg::SUM_W-1:0]             fr_sum;
    bmb_pkg::side_t                        fr_side, sq_side, dv_side;
    logic [bmb_pkg::ROOT_W-1:0]            sq_root;
    logic [2:0][bmb_pkg::Q_W-1:0]          dv_quot;
    logic [2:0][bmb_pkg::VEC_W-1:0]        bk_r0, bk_r1, bk_r2;
    logic [2:0][bmb_pkg::POS_W-1:0]        bk_tr;
    logic [bmb_pkg::OUT_W-1:0]             bk_word;

    // two-word output buffer
    logic [bmb_pkg::OUT_W-1:0]             head_reg, head_next, tail_reg, tail_next;
    logic [1:0]                            count_reg, count_next;
    logic                                  push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_mode   <= 1'b0;
            cfg_reg.axis[0]     <= 16'sd0;
            cfg_reg.axis[1]     <= 16'sd16384;
            cfg_reg.axis[2]     <= 16'sd0;
            cfg_reg.quad_width  <= 31'd65536;
            cfg_reg.quad_height <= 31'd65536;
        end else if (cfg_valid) begin
            unique case (bmb_pkg::cfg_reg_t'(cfg_index))
                bmb_pkg::REG_AXIS_MODE:   cfg_reg.axis_mode   <= cfg_data[0];
                bmb_pkg::REG_AXIS_X:      cfg_reg.axis[0]     <= cfg_data[bmb_pkg::VEC_W-1:0];
                bmb_pkg::REG_AXIS_Y:      cfg_reg.axis[1]     <= cfg_data[bmb_pkg::VEC_W-1:0];
                bmb_pkg::REG_AXIS_Z:      cfg_reg.axis[2]     <= cfg_data[bmb_pkg::VEC_W-1:0];
                bmb_pkg::REG_QUAD_WIDTH:  cfg_reg.quad_width  <= cfg_data[bmb_pkg::DIM_W-1:0];
                bmb_pkg::REG_QUAD_HEIGHT: cfg_reg.quad_height <= cfg_data[bmb_pkg::DIM_W-1:0];
                default: ;                // unused index: write dropped
            endcase
        end
    end

    // pipeline moves whenever the buffer has a free slot
    assign ce       = (count_reg != 2'd2);
    assign s_tready = ce;
    assign in_valid = s_tvalid;

    bmb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (in_valid),
        .face      (s_tdata[47:0]),
        .up        (s_tdata[95:48]),
        .pos       (s_tdata[191:96]),
        .cfg       (cfg_reg),
        .out_valid (fr_valid),
        .sum       (fr_sum),
        .side      (fr_side)
    );

    bmb_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (fr_valid),
        .sum       (fr_sum),
        .side_in   (fr_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    bmb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .side_in   (sq_side),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    bmb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (dv_valid),
        .quot      (dv_quot),
        .side      (dv_side),
        .cfg       (cfg_reg),
        .out_valid (bk_valid),
        .r0        (bk_r0),
        .r1        (bk_r1),
        .r2        (bk_r2),
        .tr        (bk_tr)
    );

    assign bk_word = {bk_tr, bk_r2, bk_r1, bk_r0};

    assign push = bk_valid && ce;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0)
                    head_next = bk_word;
                else
                    tail_next = bk_word;
                count_next = count_reg + 2'd1;
            end
            2'b01: begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11: begin
                // push implies a free slot, so at most one word is held
                head_next = bk_word;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = head_reg;

endmodule

[tb/tb_billboard_matrix_builder.sv]
`timescale 1ns / 1ps
// Testbench for billboard_matrix_builder: directed and random stream words,
// checked against an in-bench billboard matrix predictor. Depends on bmb_pkg.

module tb_billboard_matrix_builder;

    typedef struct {
        logic signed [15:0] r0 [3];
        logic signed [15:0] r1 [3];
        logic signed [15:0] r2 [3];
        logic signed [31:0] tr [3];
    } matrix_t;

    // Pending matrices and field-by-field comparison
    class matrix_board;
        matrix_t pending[$];
        int      errors;

        function void note_sprite(matrix_t m);
            pending.push_back(m);
        endfunction

        function void check_word(logic [bmb_pkg::OUT_W-1:0] w);
            matrix_t m;
            logic signed [31:0] got;
            logic signed [31:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, w);
                errors++;
                return;
            end
            m = pending.pop_front();
            for (int i = 0; i < 12; i++) begin
                if (i < 9) begin
                    got  = $signed(w[16*i +: 16]);
                    want = (i < 3) ? m.r0[i] : (i < 6) ? m.r1[i-3] : m.r2[i-6];
                end else begin
                    got  = $signed(w[144 + 32*(i-9) +: 32]);
                    want = m.tr[i-9];
                end
                if (got !== want) begin
                    $display("%0t: field %0d expected %0d actual %0d", $time, i, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                         aclk = 0;
    logic                         aresetn = 0;
    logic                         s_tvalid = 0;
    logic                         s_tready;
    logic [bmb_pkg::IN_W-1:0]     s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 0;
    logic [bmb_pkg::OUT_W-1:0]    m_tdata;
    logic                         cfg_valid = 0;
    logic                         cfg_ready;
    logic [bmb_pkg::IDX_W-1:0]    cfg_index = '0;
    logic [bmb_pkg::CFG_W-1:0]    cfg_data = '0;

    billboard_matrix_builder dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // predictor's copy of the registers
    logic               mode_q;
    longint             axis_q [3];
    longint             wid_q, hgt_q;

    matrix_board board = new();
    int  send_idle, recv_idle, words_out;
    longint cycles;

    function automatic longint round_shift(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned s);
        longint unsigned r = 0, b = longint'(1) << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic matrix_t billboard_of(logic [bmb_pkg::IN_W-1:0] d);
        matrix_t m;
        longint f[3], v[3], r0[3], r1[3], r2[3], pos[3];
        longint unsigned mg[3], s, len, q;
        longint dot, t;
        int k;
        for (int i = 0; i < 3; i++) begin
            f[i]   = -longint'($signed(d[16*i +: 16]));
            pos[i] = $signed(d[96 + 32*i +: 32]);
        end
        if (mode_q) begin
            r2 = axis_q;
            dot = f[0]*r2[0] + f[1]*r2[1] + f[2]*r2[2];
            for (int i = 0; i < 3; i++) v[i] = f[i] * (longint'(1) << 28) - dot * r2[i];
        end else
            for (int i = 0; i < 3; i++) begin
                r2[i] = $signed(d[48 + 16*i +: 16]);
                v[i]  = f[i];
            end
        // normalise: shrink magnitudes to 24 bits, then divide by the root
        for (int i = 0; i < 3; i++) mg[i] = v[i] < 0 ? -v[i] : v[i];
        k = 0;
        while ((mg[0] >> k) >= 2**24 || (mg[1] >> k) >= 2**24 || (mg[2] >> k) >= 2**24) k++;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] >>= k;
            s += mg[i] * mg[i];
        end
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            if (len == 0) r0[i] = 0;
            else begin
                q = (mg[i] * 16384 + len / 2) / len;
                if (q > 32767) q = 32767;
                r0[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
        end
        r1[0] = clamp(round_shift(r0[2]*r2[1] - r2[2]*r0[1], 14), -32768, 32767);
        r1[1] = clamp(round_shift(r2[2]*r0[0] - r0[2]*r2[0], 14), -32768, 32767);
        r1[2] = clamp(round_shift(r0[1]*r2[0] - r2[1]*r0[0], 14), -32768, 32767);
        for (int i = 0; i < 3; i++) begin
            t = pos[i] * 32768 - wid_q * r1[i] - hgt_q * r2[i];
            m.tr[i] = 32'(clamp(round_shift(t, 15), -64'sd2147483648, 64'sd2147483647));
            m.r0[i] = 16'(r0[i]);
            m.r1[i] = 16'(r1[i]);
            m.r2[i] = 16'(r2[i]);
        end
        return m;
    endfunction

    task automatic write_reg(bmb_pkg::cfg_reg_t idx, logic [bmb_pkg::CFG_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
        case (idx)
            bmb_pkg::REG_AXIS_MODE:   mode_q    = val[0];
            bmb_pkg::REG_AXIS_X:      axis_q[0] = $signed(val[15:0]);
            bmb_pkg::REG_AXIS_Y:      axis_q[1] = $signed(val[15:0]);
            bmb_pkg::REG_AXIS_Z:      axis_q[2] = $signed(val[15:0]);
            bmb_pkg::REG_QUAD_WIDTH:  wid_q     = val[30:0];
            bmb_pkg::REG_QUAD_HEIGHT: hgt_q     = val[30:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // tvalid stays high between back-to-back words; drain drops it
    task automatic send_sprite(logic [bmb_pkg::IN_W-1:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_sprite(billboard_of(d));
        @(negedge aclk);
    endtask

    // quiet the pipeline: all words back, then the latency again
    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    function automatic logic [15:0] rnd_vec();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [bmb_pkg::IN_W-1:0] rnd_sprite();
        logic [bmb_pkg::IN_W-1:0] d;
        for (int i = 0; i < 6; i++) d[16*i +: 16] = rnd_vec();
        for (int i = 0; i < 3; i++)
            d[96 + 32*i +: 32] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2**20) << 8;
        // sometimes a facing parallel to the axis, or a zero facing
        if ($urandom_range(15) == 0)
            d[47:0] = {16'(-axis_q[2]), 16'(-axis_q[1]), 16'(-axis_q[0])};
        if ($urandom_range(31) == 0) d[47:0] = '0;
        return d;
    endfunction

    // receiver: stalls at random, checks every accepted word
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);
    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) begin
            board.check_word(m_tdata);
            words_out++;
        end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [bmb_pkg::IN_W-1:0] d;
        cycles = 0; words_out = 0;
        send_idle = 0; recv_idle = 0;
        mode_q = 0; axis_q = '{0, 16384, 0}; wid_q = 65536; hgt_q = 65536;
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: extremes at reset settings
        send_sprite('0);
        send_sprite({{3{32'h7fffffff}}, {6{16'h7fff}}});
        send_sprite({{3{32'h80000000}}, {6{16'h8000}}});
        send_sprite({96'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'hc000});
        send_sprite({{3{32'h00010000}}, 48'h0, 16'h1234, 16'hf000, 16'h4000});
        drain();
        // axis mode, big quad, facing along the axis and zero axis
        write_reg(bmb_pkg::REG_AXIS_MODE, 32'd1);
        write_reg(bmb_pkg::REG_QUAD_WIDTH, 32'h7fffffff);
        write_reg(bmb_pkg::REG_QUAD_HEIGHT, 32'd0);
        send_sprite({96'h0, 48'h0, 16'h0, 16'hc000, 16'h0});
        send_sprite({96'h0, 48'h0, 16'h0, 16'h0, 16'h4000});
        send_sprite({{3{32'h7fffffff}}, 48'h0, {3{16'h8000}}});
        drain();
        write_reg(bmb_pkg::REG_AXIS_X, 32'h8000);
        write_reg(bmb_pkg::REG_AXIS_Y, 32'h7fff);
        write_reg(bmb_pkg::REG_AXIS_Z, 32'h8000);
        send_sprite({{3{32'h80000000}}, 48'h0, {3{16'h7fff}}});
        send_sprite({96'h0, 48'h0, 16'h1, 16'h2, 16'h3});
        drain();
        write_reg(bmb_pkg::REG_AXIS_X, 32'd0);
        write_reg(bmb_pkg::REG_AXIS_Y, 32'd0);
        write_reg(bmb_pkg::REG_AXIS_Z, 32'd0);
        send_sprite({96'h0, 48'h0, 16'h100, 16'h200, 16'hff00});
        drain();

        // random phases across idling patterns and settings
        for (int ph = 0; ph < 6; ph++) begin
            send_idle = (ph < 2) ? 21 : (ph < 4) ? 65 : 0;
            recv_idle = (ph < 2) ? 65 : (ph < 4) ? 21 : 0;
            write_reg(bmb_pkg::REG_AXIS_MODE, 32'(ph % 2));
            write_reg(bmb_pkg::REG_AXIS_X, (ph == 5) ? 32'h8000 :
                      {$urandom_range(1) ? 16'hffff : 16'h0,
                       16'(int'($urandom_range(32768)) - 16384)});
            write_reg(bmb_pkg::REG_AXIS_Y, (ph == 5) ? 32'h7fff : $urandom);
            write_reg(bmb_pkg::REG_AXIS_Z, $urandom_range(1) ? 32'h4000 : $urandom);
            write_reg(bmb_pkg::REG_QUAD_WIDTH,
                      (ph == 4) ? 32'h7fffffff : $urandom_range(2**20));
            write_reg(bmb_pkg::REG_QUAD_HEIGHT,
                      (ph == 4) ? 32'h7fffffff : (ph == 3) ? 32'd0 : $urandom);
            for (int n = 0; n < 325; n++) begin
                d = rnd_sprite();
                send_sprite(d);
            end
            drain();
        end

        $display("Covered %0d matrices over both row-two modes, three idling patterns", words_out);
        $display("and register extremes, with %0d mismatches.", board.errors);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
